@@ hw/rtl/icp_pkg.sv @@
// Shared types and constants for the ICMP ping controller.
// Used by icp_cfg_regs, icp_engine and icmp_ping_controller; no dependencies.
package icp_pkg;

  typedef enum logic [1:0] {
    OP_START = 2'd0,
    OP_POLL  = 2'd1,
    OP_MSG   = 2'd2
  } opcode_e;

  typedef enum logic [1:0] {
    ACT_NONE       = 2'd0,
    ACT_ARP_REQ    = 2'd1,
    ACT_ECHO_REQ   = 2'd2,
    ACT_ECHO_REPLY = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    ST_PENDING = 2'd0,
    ST_SUCCESS = 2'd1,
    ST_TIMEOUT = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_ARP   = 2'd1,
    PH_REPLY = 2'd2
  } phase_e;

  localparam int unsigned CfgIdxW = 3;
  localparam logic [CfgIdxW-1:0] CFG_OWN_ADDR   = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_SUBNET     = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_GATEWAY    = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_TIMEOUT    = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_IDENTIFIER = 3'd4;

  localparam logic [15:0] TIMEOUT_RESET    = 16'd300;
  localparam logic [15:0] IDENTIFIER_RESET = 16'hA1B2;

  localparam logic [7:0]  ICMP_ECHO_REQUEST = 8'd8;
  localparam logic [7:0]  ICMP_ECHO_REPLY   = 8'd0;
  localparam logic [15:0] MIN_MSG_LEN       = 16'd8;

  typedef struct packed {
    logic [31:0] own_address;
    logic [31:0] subnet_mask;
    logic [31:0] gateway_address;
    logic [15:0] timeout_ticks;
    logic [15:0] echo_identifier;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [31:0] destination;
    logic [31:0] now_ticks;
    logic        hop_cached;
    logic [31:0] source;
    logic [7:0]  msg_type;
    logic [15:0] msg_identifier;
    logic [15:0] msg_sequence;
    logic [15:0] msg_length;
  } in_item_t;

  typedef struct packed {
    action_e     action;
    logic [31:0] target;
    logic [15:0] out_sequence;
    logic [7:0]  reply_length;
    status_e     status;
    logic [31:0] round_trip;
  } out_item_t;

endpackage

@@ hw/rtl/icp_cfg_regs.sv @@
// Configuration register file of the ICMP ping controller.
// Depends on icp_pkg for the register indexes and the cfg_t bundle.
module icp_cfg_regs (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [icp_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [31:0]                    cfg_data_i,
  output icp_pkg::cfg_t                  cfg_o
);

  icp_pkg::cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        icp_pkg::CFG_OWN_ADDR:   cfg_d.own_address     = cfg_data_i;
        icp_pkg::CFG_SUBNET:     cfg_d.subnet_mask     = cfg_data_i;
        icp_pkg::CFG_GATEWAY:    cfg_d.gateway_address = cfg_data_i;
        icp_pkg::CFG_TIMEOUT:    cfg_d.timeout_ticks   = cfg_data_i[15:0];
        icp_pkg::CFG_IDENTIFIER: cfg_d.echo_identifier = cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.own_address     <= '0;
      cfg_q.subnet_mask     <= '0;
      cfg_q.gateway_address <= '0;
      cfg_q.timeout_ticks   <= icp_pkg::TIMEOUT_RESET;
      cfg_q.echo_identifier <= icp_pkg::IDENTIFIER_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

@@ hw/rtl/icp_engine.sv @@
// Ping state (phase, sequence, pending ping, received reply) and the
// per-event decision logic. Depends on icp_pkg.
module icp_engine #(
  parameter int unsigned MaxReplyBytes = 128
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_i,
  input  icp_pkg::in_item_t   item_i,
  input  icp_pkg::cfg_t       cfg_i,
  output icp_pkg::out_item_t  res_o
);

  localparam int unsigned LenCap = (MaxReplyBytes > 255) ? 255 : MaxReplyBytes;
  localparam logic [15:0] LenCapW = 16'(LenCap);

  icp_pkg::phase_e phase_q, phase_d;
  logic [15:0] seq_cnt_q, seq_cnt_d;
  logic        reply_flag_q, reply_flag_d;
  logic [15:0] reply_seq_q, reply_seq_d;
  logic [31:0] pend_dest_q, pend_dest_d;
  logic [15:0] pend_seq_q, pend_seq_d;
  logic [31:0] start_time_q, start_time_d;
  logic [31:0] deadline_q, deadline_d;

  logic [15:0] seq_next;
  logic        on_subnet;
  logic [31:0] next_hop;
  logic        timed_out;
  logic        got_reply;
  logic        arp_wait;
  logic        msg_ok;
  logic [7:0]  echo_len;

  assign seq_next  = seq_cnt_q + 16'd1;
  assign on_subnet = (item_i.destination & cfg_i.subnet_mask) ==
                     (cfg_i.own_address & cfg_i.subnet_mask);
  assign next_hop  = on_subnet ? item_i.destination : cfg_i.gateway_address;
  assign timed_out = item_i.now_ticks >= deadline_q;
  assign got_reply = reply_flag_q && (reply_seq_q == pend_seq_q);
  // still waiting on ARP and the cache has not resolved the hop yet
  assign arp_wait  = (phase_q == icp_pkg::PH_ARP) && !item_i.hop_cached;
  assign msg_ok    = item_i.msg_length >= icp_pkg::MIN_MSG_LEN;
  assign echo_len  = (item_i.msg_length > LenCapW) ? LenCapW[7:0]
                                                   : item_i.msg_length[7:0];

  // Next phase
  always_comb begin
    phase_d = phase_q;
    unique case (icp_pkg::opcode_e'(item_i.opcode))
      icp_pkg::OP_START: begin
        phase_d = item_i.hop_cached ? icp_pkg::PH_REPLY : icp_pkg::PH_ARP;
      end
      icp_pkg::OP_POLL: begin
        if (arp_wait) begin
          if (timed_out) phase_d = icp_pkg::PH_IDLE;
        end else if (got_reply || timed_out) begin
          phase_d = icp_pkg::PH_IDLE;
        end else if (phase_q == icp_pkg::PH_ARP) begin
          phase_d = icp_pkg::PH_REPLY;
        end
      end
      default: ;
    endcase
  end

  // Result and data state
  always_comb begin
    res_o        = '0;
    seq_cnt_d    = seq_cnt_q;
    reply_flag_d = reply_flag_q;
    reply_seq_d  = reply_seq_q;
    pend_dest_d  = pend_dest_q;
    pend_seq_d   = pend_seq_q;
    start_time_d = start_time_q;
    deadline_d   = deadline_q;
    unique case (icp_pkg::opcode_e'(item_i.opcode))
      icp_pkg::OP_START: begin
        seq_cnt_d    = seq_next;
        reply_flag_d = 1'b0;
        reply_seq_d  = '0;
        pend_seq_d   = seq_next;
        pend_dest_d  = item_i.destination;
        start_time_d = item_i.now_ticks;
        deadline_d   = item_i.now_ticks + 32'(cfg_i.timeout_ticks);
        if (item_i.hop_cached) begin
          res_o.action       = icp_pkg::ACT_ECHO_REQ;
          res_o.target       = item_i.destination;
          res_o.out_sequence = seq_next;
        end else begin
          res_o.action = icp_pkg::ACT_ARP_REQ;
          res_o.target = next_hop;
        end
      end
      icp_pkg::OP_POLL: begin
        if (arp_wait) begin
          if (timed_out) res_o.status = icp_pkg::ST_TIMEOUT;
        end else begin
          if (phase_q == icp_pkg::PH_ARP) begin
            res_o.action       = icp_pkg::ACT_ECHO_REQ;
            res_o.target       = pend_dest_q;
            res_o.out_sequence = pend_seq_q;
          end
          if (got_reply) begin
            res_o.status     = icp_pkg::ST_SUCCESS;
            res_o.round_trip = item_i.now_ticks - start_time_q;
          end else if (timed_out) begin
            res_o.status = icp_pkg::ST_TIMEOUT;
          end
        end
      end
      icp_pkg::OP_MSG: begin
        if (msg_ok) begin
          if (item_i.msg_type == icp_pkg::ICMP_ECHO_REQUEST) begin
            res_o.action       = icp_pkg::ACT_ECHO_REPLY;
            res_o.target       = item_i.source;
            res_o.reply_length = echo_len;
          end else if (item_i.msg_type == icp_pkg::ICMP_ECHO_REPLY &&
                       item_i.msg_identifier == cfg_i.echo_identifier) begin
            reply_seq_d  = item_i.msg_sequence;
            reply_flag_d = 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= icp_pkg::PH_IDLE;
      seq_cnt_q    <= '0;
      reply_flag_q <= 1'b0;
      reply_seq_q  <= '0;
      pend_dest_q  <= '0;
      pend_seq_q   <= '0;
      start_time_q <= '0;
      deadline_q   <= '0;
    end else if (step_i) begin
      phase_q      <= phase_d;
      seq_cnt_q    <= seq_cnt_d;
      reply_flag_q <= reply_flag_d;
      reply_seq_q  <= reply_seq_d;
      pend_dest_q  <= pend_dest_d;
      pend_seq_q   <= pend_seq_d;
      start_time_q <= start_time_d;
      deadline_q   <= deadline_d;
    end
  end

endmodule

@@ hw/rtl/icmp_ping_controller.sv @@
// Top level of the ICMP ping controller: input register, engine, result register.
// Depends on icp_pkg, icp_cfg_regs and icp_engine.

// Event-driven ping client with one ping outstanding. Each event (start,
// poll, received ICMP message) yields exactly one result. An accepted event
// is held in the input register, evaluated by the engine and registered into
// the result register once that register can take it; out_valid_o then rises
// and the result is taken on a clock edge where out_stall_i is low.
// One event per cycle is sustained while out_stall_i is low. The input
// register stalls only when the result register is full and held.
// Configuration writes are always ready and take effect on the next cycle;
// write them while no event is in flight.
module icmp_ping_controller #(
  parameter int unsigned MaxReplyBytes = 128
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // configuration
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [icp_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [31:0]                  cfg_data_i,
  // events
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [1:0]                   opcode_i,
  input  logic [31:0]                  destination_i,
  input  logic [31:0]                  now_ticks_i,
  input  logic                         hop_cached_i,
  input  logic [31:0]                  source_i,
  input  logic [7:0]                   msg_type_i,
  input  logic [15:0]                  msg_identifier_i,
  input  logic [15:0]                  msg_sequence_i,
  input  logic [15:0]                  msg_length_i,
  // results
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [1:0]                   action_o,
  output logic [31:0]                  target_o,
  output logic [15:0]                  out_sequence_o,
  output logic [7:0]                   reply_length_o,
  output logic [1:0]                   status_o,
  output logic [31:0]                  round_trip_o
);

  icp_pkg::cfg_t      cfg;
  icp_pkg::in_item_t  in_q;
  icp_pkg::out_item_t out_q, res;

  logic in_vld_q, in_vld_d;
  logic out_vld_q, out_vld_d;
  logic advance;
  logic in_fire;
  logic step;

  icp_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // result register can take a new entry
  assign advance    = !out_vld_q || !out_stall_i;
  assign step       = in_vld_q && advance;
  assign in_stall_o = in_vld_q && !advance;
  assign in_fire    = in_valid_i && !in_stall_o;

  assign in_vld_d  = in_fire || (in_vld_q && !advance);
  assign out_vld_d = step || (out_vld_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      in_q.opcode         <= opcode_i;
      in_q.destination    <= destination_i;
      in_q.now_ticks      <= now_ticks_i;
      in_q.hop_cached     <= hop_cached_i;
      in_q.source         <= source_i;
      in_q.msg_type       <= msg_type_i;
      in_q.msg_identifier <= msg_identifier_i;
      in_q.msg_sequence   <= msg_sequence_i;
      in_q.msg_length     <= msg_length_i;
    end
    if (step) begin
      out_q <= res;
    end
  end

  icp_engine #(
    .MaxReplyBytes (MaxReplyBytes)
  ) u_engine (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .item_i (in_q),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  assign out_valid_o    = out_vld_q;
  assign action_o       = out_q.action;
  assign target_o       = out_q.target;
  assign out_sequence_o = out_q.out_sequence;
  assign reply_length_o = out_q.reply_length;
  assign status_o       = out_q.status;
  assign round_trip_o   = out_q.round_trip;

  // a stall on the input side only comes from a full, held result register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_vld_q && out_stall_i))
    else $error("input stalled while result register free");

  // every start transaction produces an ARP or an echo request
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step && in_q.opcode == icp_pkg::OP_START) |=>
      (out_vld_q && (out_q.action == icp_pkg::ACT_ARP_REQ ||
                     out_q.action == icp_pkg::ACT_ECHO_REQ)))
    else $error("start transaction without a request");

  // a round-trip time is only reported with success
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && out_q.round_trip != 32'd0) |-> (out_q.status == icp_pkg::ST_SUCCESS))
    else $error("round trip reported without success");

endmodule
